// ----- hw/rtl/rtp_pkg.sv -----
// rtp_pkg: widths, constants, angle table and shared types of the rect_to_polar block
// used by every module of the block; depends on nothing

package rtp_pkg;

  localparam int SAMPLE_WIDTH   = 16;
  localparam int ROTATION_STEPS = 16;
  localparam int GUARD_BITS     = 8;

  // datapath x, y: sample magnitude with guard bits, headroom for gain and sqrt(2)
  localparam int XY_W = SAMPLE_WIDTH + GUARD_BITS + 3;
  localparam int UX_W = XY_W - 1;
  // angle accumulator in Q30 radians
  localparam int Z_W     = 33;
  localparam int Z_SHIFT = 17;
  localparam int ZRND    = 1 << (Z_SHIFT - 1);
  localparam int AR_W    = Z_W - Z_SHIFT;

  // gain compensation K in Q30, split in a high and a low 15-bit part
  localparam int GAIN_Q30  = 652032874;
  localparam int K_SPLIT   = 15;
  localparam int KH        = GAIN_Q30 >> K_SPLIT;
  localparam int KL        = GAIN_Q30 & ((1 << K_SPLIT) - 1);
  localparam int PROD_W    = UX_W + K_SPLIT;
  localparam int PLO_W     = PROD_W - K_SPLIT;
  localparam int SUM_W     = PROD_W + 1;
  localparam int MAG_SHIFT = K_SPLIT + GUARD_BITS;
  localparam int MAG_RND   = 1 << (MAG_SHIFT - 1);

  localparam int MAG_W      = 16;
  localparam int MAG_MAX    = 65535;
  localparam int PH_W       = 16;
  localparam int ANG_W      = 14;
  localparam int PH_PI      = 25736;
  localparam int PH_HALF_PI = 12868;

  // input register, rotation stages, product stage, output register
  localparam int LATENCY = ROTATION_STEPS + 3;

  // atan(2^-i) in Q30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159, 32'd67021687,
    32'd33543516,  32'd16775851,  32'd8388437,   32'd4194283,   32'd2097149,
    32'd1048576,   32'd524288,    32'd262144,    32'd131072,    32'd65536,
    32'd32768,     32'd16384,     32'd8192,      32'd4096,      32'd2048,
    32'd1024,      32'd512,       32'd256,       32'd128,       32'd64,
    32'd32,        32'd16,        32'd8,         32'd4,         32'd2,
    32'd1,         32'd0
  };

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
  } vec_t;

  // sideband that travels with each item
  typedef struct packed {
    logic                    last;
    logic                    re_neg;
    logic                    re_zero;
    logic                    im_neg;
    logic                    im_zero;
    logic [SAMPLE_WIDTH-1:0] smag;
  } flags_t;

endpackage

// ----- hw/rtl/rect_to_polar.sv -----
// rect_to_polar: top level, pipelined cordic that turns a complex sample into
// magnitude and phase; depends on rtp_pkg, rtp_fold, rtp_cordic_pipe, rtp_post
//
//   channel   handshake              payload
//   input     start high, busy low   re_part_i, im_part_i, last_in_i
//   result    done_o one cycle       magnitude_o, phase_o, last_out_o
//
// one item per clock; every item gives exactly one result
// registers on the path: input register, one register stage per cordic rotation,
// product stage, output register
// busy is never raised: the pipeline always moves and the receiver cannot stall
// reset clears the valid bits of all stages, payload registers are not reset

module rect_to_polar (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] re_part_i,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] im_part_i,
  input  logic                                    last_in_i,
  output logic                                    done_o,
  output logic [rtp_pkg::MAG_W-1:0]               magnitude_o,
  output logic signed [rtp_pkg::PH_W-1:0]         phase_o,
  output logic                                    last_out_o
);

  logic            fold_valid, rot_valid;
  rtp_pkg::vec_t   fold_vec, rot_vec;
  rtp_pkg::flags_t fold_flags, rot_flags;

  // nothing ever holds the pipeline
  assign busy = 1'b0;

  // abs values, axis and sign flags
  rtp_fold u_fold (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .re_i    (re_part_i),
    .im_i    (im_part_i),
    .last_i  (last_in_i),
    .valid_o (fold_valid),
    .vec_o   (fold_vec),
    .flags_o (fold_flags)
  );

  // vectoring rotations, angle summed along the way
  rtp_cordic_pipe u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fold_valid),
    .vec_i   (fold_vec),
    .flags_i (fold_flags),
    .valid_o (rot_valid),
    .vec_o   (rot_vec),
    .flags_o (rot_flags)
  );

  // gain compensation, rounding, quadrant restore and axis cases
  rtp_post u_post (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (rot_valid),
    .vec_i   (rot_vec),
    .flags_i (rot_flags),
    .done_o  (done_o),
    .mag_o   (magnitude_o),
    .phase_o (phase_o),
    .last_o  (last_out_o)
  );

endmodule

// ----- hw/rtl/rtp_fold.sv -----
// rtp_fold: input register stage, folds the sample into the first quadrant
// depends on rtp_pkg

module rtp_fold (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  valid_i,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] re_i,
  input  logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] im_i,
  input  logic                                  last_i,
  output logic                                  valid_o,
  output rtp_pkg::vec_t                         vec_o,
  output rtp_pkg::flags_t                       flags_o
);

  logic [rtp_pkg::SAMPLE_WIDTH-1:0] re_u, im_u, ax, ay;
  logic                             valid_q;
  rtp_pkg::vec_t                    vec_d, vec_q;
  rtp_pkg::flags_t                  flags_d, flags_q;

  always_comb begin
    re_u = re_i;
    im_u = im_i;
    ax   = re_i[rtp_pkg::SAMPLE_WIDTH-1] ? (~re_u + 1'b1) : re_u;
    ay   = im_i[rtp_pkg::SAMPLE_WIDTH-1] ? (~im_u + 1'b1) : im_u;

    vec_d.x = rtp_pkg::XY_W'({ax, {rtp_pkg::GUARD_BITS{1'b0}}});
    vec_d.y = rtp_pkg::XY_W'({ay, {rtp_pkg::GUARD_BITS{1'b0}}});
    vec_d.z = '0;

    flags_d.last    = last_i;
    flags_d.re_neg  = re_i[rtp_pkg::SAMPLE_WIDTH-1];
    flags_d.re_zero = (re_u == '0);
    flags_d.im_neg  = im_i[rtp_pkg::SAMPLE_WIDTH-1];
    flags_d.im_zero = (im_u == '0);
    // on an axis the magnitude is the other part's absolute value
    flags_d.smag    = (re_u == '0) ? ay : ax;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q   <= vec_d;
    flags_q <= flags_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;
  assign flags_o = flags_q;

endmodule

// ----- hw/rtl/rtp_cordic_pipe.sv -----
// rtp_cordic_pipe: vectoring rotations, one register stage per rotation
// depends on rtp_pkg

module rtp_cordic_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  rtp_pkg::vec_t   vec_i,
  input  rtp_pkg::flags_t flags_i,
  output logic            valid_o,
  output rtp_pkg::vec_t   vec_o,
  output rtp_pkg::flags_t flags_o
);

  localparam int N = rtp_pkg::ROTATION_STEPS;

  logic            valid_q [N];
  rtp_pkg::vec_t   vec_q   [N];
  rtp_pkg::flags_t flags_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                            src_valid;
    rtp_pkg::vec_t                   src, nxt;
    rtp_pkg::flags_t                 src_flags;
    logic signed [rtp_pkg::XY_W-1:0] dx, dy;
    logic signed [rtp_pkg::Z_W-1:0]  da;

    if (k == 0) begin : g_first
      assign src_valid = valid_i;
      assign src       = vec_i;
      assign src_flags = flags_i;
    end else begin : g_next
      assign src_valid = valid_q[k-1];
      assign src       = vec_q[k-1];
      assign src_flags = flags_q[k-1];
    end

    always_comb begin
      dx = $signed(src.y) >>> k;
      dy = $signed(src.x) >>> k;
      da = rtp_pkg::Z_W'(rtp_pkg::ATAN_Q30[k]);
      // rotate toward the real axis: direction from the sign of y
      if (!src.y[rtp_pkg::XY_W-1]) begin
        nxt.x = src.x + dx;
        nxt.y = src.y - dy;
        nxt.z = src.z + da;
      end else begin
        nxt.x = src.x - dx;
        nxt.y = src.y + dy;
        nxt.z = src.z - da;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[k] <= 1'b0;
      end else begin
        valid_q[k] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      vec_q[k]   <= nxt;
      flags_q[k] <= src_flags;
    end
  end

  assign valid_o = valid_q[N-1];
  assign vec_o   = vec_q[N-1];
  assign flags_o = flags_q[N-1];

endmodule

// ----- hw/rtl/rtp_post.sv -----
// rtp_post: gain compensation, angle rounding and quadrant restore, output register
// depends on rtp_pkg

module rtp_post (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               valid_i,
  input  rtp_pkg::vec_t                      vec_i,
  input  rtp_pkg::flags_t                    flags_i,
  output logic                               done_o,
  output logic [rtp_pkg::MAG_W-1:0]          mag_o,
  output logic signed [rtp_pkg::PH_W-1:0]    phase_o,
  output logic                               last_o
);

  // product stage
  logic [rtp_pkg::UX_W-1:0]         ux;
  logic [rtp_pkg::PROD_W-1:0]       phi_d, phi_q, prod_lo;
  logic [rtp_pkg::PLO_W-1:0]        plo_d, plo_q;
  logic signed [rtp_pkg::Z_W-1:0]   zr;
  logic signed [rtp_pkg::AR_W-1:0]  ar;
  logic [rtp_pkg::ANG_W-1:0]        ang_d, ang_q;
  rtp_pkg::flags_t                  flags_q;
  logic                             valid_q;

  // output stage
  logic [rtp_pkg::SUM_W-1:0]        sum, mag_src;
  logic [rtp_pkg::PH_W-1:0]         ang_ext, half_t, ph_d;
  logic [rtp_pkg::MAG_W-1:0]        mag_d, mag_q;
  logic [rtp_pkg::PH_W-1:0]         ph_q;
  logic                             special;
  logic                             done_q, last_q;

  always_comb begin
    ux      = (vec_i.x > 0) ? rtp_pkg::UX_W'(vec_i.x) : '0;
    phi_d   = rtp_pkg::PROD_W'(ux) * rtp_pkg::PROD_W'(rtp_pkg::KH);
    prod_lo = rtp_pkg::PROD_W'(ux) * rtp_pkg::PROD_W'(rtp_pkg::KL);
    plo_d   = prod_lo[rtp_pkg::PROD_W-1:rtp_pkg::K_SPLIT];

    // Q30 to Q3.13 with half-up rounding, then clamp to 0..pi/2
    zr = vec_i.z + rtp_pkg::Z_W'(rtp_pkg::ZRND);
    ar = zr[rtp_pkg::Z_W-1:rtp_pkg::Z_SHIFT];
    if (ar[rtp_pkg::AR_W-1]) begin
      ang_d = '0;
    end else if (ar > $signed(rtp_pkg::AR_W'(rtp_pkg::PH_HALF_PI))) begin
      ang_d = rtp_pkg::ANG_W'(rtp_pkg::PH_HALF_PI);
    end else begin
      ang_d = ar[rtp_pkg::ANG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      valid_q <= valid_i;
      done_q  <= valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    phi_q   <= phi_d;
    plo_q   <= plo_d;
    ang_q   <= ang_d;
    flags_q <= flags_i;
  end

  always_comb begin
    special = flags_q.re_zero | flags_q.im_zero;
    sum = rtp_pkg::SUM_W'(phi_q) + rtp_pkg::SUM_W'(plo_q)
        + rtp_pkg::SUM_W'(rtp_pkg::MAG_RND);
    mag_src = special ? rtp_pkg::SUM_W'(flags_q.smag) : (sum >> rtp_pkg::MAG_SHIFT);
    if (mag_src > rtp_pkg::SUM_W'(rtp_pkg::MAG_MAX)) begin
      mag_d = rtp_pkg::MAG_W'(rtp_pkg::MAG_MAX);
    end else begin
      mag_d = mag_src[rtp_pkg::MAG_W-1:0];
    end

    ang_ext = rtp_pkg::PH_W'(ang_q);
    half_t  = flags_q.re_neg ? (rtp_pkg::PH_W'(rtp_pkg::PH_PI) - ang_ext) : ang_ext;
    if (flags_q.re_zero) begin
      if (flags_q.im_zero) begin
        ph_d = '0;
      end else if (flags_q.im_neg) begin
        ph_d = -rtp_pkg::PH_W'(rtp_pkg::PH_HALF_PI);
      end else begin
        ph_d = rtp_pkg::PH_W'(rtp_pkg::PH_HALF_PI);
      end
    end else if (flags_q.im_zero) begin
      // negative real axis gives +pi
      ph_d = flags_q.re_neg ? rtp_pkg::PH_W'(rtp_pkg::PH_PI) : '0;
    end else begin
      ph_d = flags_q.im_neg ? -half_t : half_t;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    ph_q   <= ph_d;
    last_q <= flags_q.last;
  end

  assign done_o  = done_q;
  assign mag_o   = mag_q;
  assign phase_o = ph_q;
  assign last_o  = last_q;

endmodule

// ----- hw/rtl/rtp_checker.sv -----
// rtp_checker: port-level assertions for rect_to_polar, bound to the top level
// depends on rtp_pkg and rect_to_polar

module rtp_checker (
  input logic                                    clk_i,
  input logic                                    rst_ni,
  input logic                                    start,
  input logic                                    busy,
  input logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] re_part_i,
  input logic signed [rtp_pkg::SAMPLE_WIDTH-1:0] im_part_i,
  input logic                                    last_in_i,
  input logic                                    done_o,
  input logic [rtp_pkg::MAG_W-1:0]               magnitude_o,
  input logic signed [rtp_pkg::PH_W-1:0]         phase_o,
  input logic                                    last_out_o
);

  localparam int LAT = rtp_pkg::LATENCY;

  logic acc;
  assign acc = start & ~busy;

  // one result per item
  a_result_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT done_o)
    else $error("item gave no result at the expected cycle");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !acc |-> ##LAT !done_o)
    else $error("result without an item");

  // frame marker comes out with its own item
  a_last_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |-> ##LAT (last_out_o == $past(last_in_i, LAT)))
    else $error("last flag out of order");

  // lower half plane never yields a positive phase
  a_phase_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && im_part_i < 0) |-> ##LAT (phase_o <= 0))
    else $error("phase sign does not match imaginary part");

  a_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && re_part_i == 0 && im_part_i == 0) |-> ##LAT
      (magnitude_o == 0 && phase_o == 0))
    else $error("zero sample gave nonzero result");

endmodule

bind rect_to_polar rtp_checker u_rtp_checker (.*);
